>>> rtl/pprd_pkg.sv
// Package with shared constants and types for the pixel packet decoder.
package pprd_pkg;

  localparam int FRAME_BYTES = 4096;
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int HDR_LEN = 14;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_ENCODING  = 4'd4;
  localparam logic [3:0] ST_COLOR     = 4'd5;
  localparam logic [3:0] ST_OVERFLOW  = 4'd6;
  localparam logic [3:0] ST_TRUNCATED = 4'd7;
  localparam logic [3:0] ST_KEYFRAME  = 4'd8;

  localparam logic [1:0] ENC_RAW   = 2'd0;
  localparam logic [1:0] ENC_RLE   = 2'd1;
  localparam logic [1:0] ENC_DELTA = 2'd2;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_READ   = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic [11:0] read_addr;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  status;
    logic [7:0]  seq;
    logic [15:0] first_px;
    logic [15:0] px_count;
    logic [1:0]  encoding;
    logic [1:0]  cspace;
    logic [7:0]  transfer;
    logic [12:0] body_len;
    logic [7:0]  read_data;
  } rsp_t;

  function automatic logic [1:0] bytes_per_px(input logic [1:0] cs);
    return (cs == 2'd1 || cs == 2'd2) ? 2'd2 : 2'd3;
  endfunction

endpackage

>>> rtl/pprd_req_if.sv
// Valid/ready channel interface carrying decoder requests.
interface pprd_req_if;
  logic          valid;
  logic          ready;
  pprd_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pprd_rsp_if.sv
// Valid/ready channel interface carrying decoder results.
interface pprd_rsp_if;
  logic          valid;
  logic          ready;
  pprd_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pixel_packet_rle_delta_decoder.sv
// Top level of the pixel packet decoder with run-length and XOR delta body coding.
// A packet byte request is taken and then handled in a sequencer step. A read
// request is taken, answered from the registered frame store read, and then waits
// in the output register until the result is taken. The last byte of a packet takes
// its step, then the report is formed and waits in the output register. A completed
// run-length pair expands through a single shared byte-write step, one frame store
// byte per cycle, and an XOR delta run needs a read and a write per byte; the run
// expands after the step that took its last pixel byte. The block takes no new
// request while a run is expanding or while a result waits in the output register,
// and a result waits there for as long as the receiver holds ready low. The frame
// store is not cleared after reset; reading an entry never written returns unknown
// data.
module pixel_packet_rle_delta_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  pprd_req_if.sink    req,
  pprd_rsp_if.source  rsp
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_RUNRD  = 3'd2;
  localparam logic [2:0] S_RUNWR  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  // Packet decoding phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_RAW    = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_FAIL   = 3'd5;

  logic [2:0]  state;
  logic [12:0] buffer_bytes;
  pprd_pkg::req_t cur;
  pprd_pkg::rsp_t out_reg;
  pprd_pkg::rsp_t rsp_next;

  logic        ref_valid;
  logic [12:0] ref_bytes;
  logic [15:0] ref_pixels;
  logic [1:0]  ref_color;
  logic [55:0] header_latch;
  logic [4:0]  header_pos;
  logic [3:0]  error_code;
  logic [8:0]  run_length;
  logic [23:0] pixel_hold;
  logic [16:0] pixels_done;
  logic [17:0] write_ptr;
  logic [1:0]  byte_idx;
  logic [2:0]  phase;
  logic [8:0]  run_left;
  logic [1:0]  run_k;

  // The frame store, with one write port and one registered read port.
  logic [7:0] mem [pprd_pkg::FRAME_BYTES];
  logic [7:0] mem_q;
  logic       mem_we;
  logic [pprd_pkg::ADDR_W-1:0] mem_waddr;
  logic [pprd_pkg::ADDR_W-1:0] mem_raddr;
  logic [7:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // Header fields.
  logic [15:0] h_count;
  logic [1:0]  h_cs;
  logic [1:0]  h_enc;
  logic [1:0]  bpp;
  logic [17:0] need;
  logic [12:0] limit;
  assign h_count = header_latch[15:0];
  assign h_cs    = header_latch[49:48];
  assign h_enc   = header_latch[51:50];
  assign bpp     = pprd_pkg::bytes_per_px(h_cs);
  assign need    = h_count * bpp;
  assign limit   = (buffer_bytes < 13'(pprd_pkg::FRAME_BYTES)) ? buffer_bytes
                 : 13'(pprd_pkg::FRAME_BYTES);

  // Current run byte address and data.
  logic [17:0] run_addr;
  logic [7:0]  run_byte;
  assign run_addr = write_ptr + 18'(run_k);
  assign run_byte = pixel_hold[8*run_k +: 8];

  always_comb begin
    mem_raddr = (state == S_IDLE) ? req.payload.read_addr[pprd_pkg::ADDR_W-1:0]
              : run_addr[pprd_pkg::ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = write_ptr[pprd_pkg::ADDR_W-1:0];
    mem_wdata = cur.packet_byte;
    if (state == S_STEP && cur.req_type == pprd_pkg::REQ_PACKET && phase == PH_RAW &&
        header_pos == 5'(pprd_pkg::HDR_LEN)) begin
      mem_we = (write_ptr < 18'(pprd_pkg::FRAME_BYTES));
    end else if (state == S_RUNWR) begin
      mem_we    = (run_addr < 18'(pprd_pkg::FRAME_BYTES));
      mem_waddr = run_addr[pprd_pkg::ADDR_W-1:0];
      mem_wdata = (h_enc == pprd_pkg::ENC_DELTA) ? (mem_q ^ run_byte) : run_byte;
    end
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = (state == S_OUT);
  assign rsp.payload = out_reg;

  logic [8:0] run_in;
  assign run_in = (cur.packet_byte == 8'd0) ? 9'd256 : {1'b0, cur.packet_byte};

  // A pixel byte that completes its pixel hands the run to the expansion loop.
  logic run_start;
  assign run_start = (header_pos == 5'(pprd_pkg::HDR_LEN)) && (phase == PH_PIXEL) &&
                     (byte_idx + 2'd1 >= bpp);

  // Header byte handling: the latch and error code as they stand after this byte,
  // and, for the final header byte, the phase and error that the header settles on.
  // Checks follow the byte order, so the first error found is the one kept.
  logic [55:0] hdr_hl;
  logic [3:0]  hdr_err;
  logic [15:0] hdr_cnt;
  logic [1:0]  hdr_cs;
  logic [1:0]  hdr_enc;
  logic [17:0] hdr_need;
  logic [3:0]  end_err;
  logic [2:0]  end_phase;

  always_comb begin
    hdr_hl  = header_latch;
    hdr_err = error_code;
    unique case (header_pos)
      5'd0: if (cur.packet_byte != 8'h44 && hdr_err == pprd_pkg::ST_OK)
              hdr_err = pprd_pkg::ST_MAGIC;
      5'd1: if (cur.packet_byte != 8'h4D && hdr_err == pprd_pkg::ST_OK)
              hdr_err = pprd_pkg::ST_MAGIC;
      5'd2: if (cur.packet_byte != 8'h58 && hdr_err == pprd_pkg::ST_OK)
              hdr_err = pprd_pkg::ST_MAGIC;
      5'd3: if (cur.packet_byte != 8'h32 && hdr_err == pprd_pkg::ST_OK)
              hdr_err = pprd_pkg::ST_MAGIC;
      5'd4: if (cur.packet_byte != 8'd1 && hdr_err == pprd_pkg::ST_OK)
              hdr_err = pprd_pkg::ST_VERSION;
      5'd6: begin
        if (cur.packet_byte > 8'd2 && hdr_err == pprd_pkg::ST_OK)
          hdr_err = pprd_pkg::ST_ENCODING;
        hdr_hl[51:50] = cur.packet_byte[1:0];
      end
      5'd7: begin
        if (cur.packet_byte > 8'd3 && hdr_err == pprd_pkg::ST_OK)
          hdr_err = pprd_pkg::ST_COLOR;
        hdr_hl[49:48] = cur.packet_byte[1:0];
      end
      5'd8:  hdr_hl[47:40] = cur.packet_byte;
      5'd9:  hdr_hl[39:32] = cur.packet_byte;
      5'd10: hdr_hl[31:24] = cur.packet_byte;
      5'd11: hdr_hl[23:16] = cur.packet_byte;
      5'd12: hdr_hl[15:8]  = cur.packet_byte;
      5'd13: hdr_hl[7:0]   = cur.packet_byte;
      default: ;
    endcase
    hdr_cnt  = hdr_hl[15:0];
    hdr_cs   = hdr_hl[49:48];
    hdr_enc  = hdr_hl[51:50];
    hdr_need = hdr_cnt * pprd_pkg::bytes_per_px(hdr_cs);
    end_err   = hdr_err;
    end_phase = PH_FAIL;
    if (hdr_err != pprd_pkg::ST_OK) begin
      end_phase = PH_FAIL;
    end else if (hdr_need > 18'(limit)) begin
      end_err = pprd_pkg::ST_OVERFLOW;
    end else if (hdr_enc == pprd_pkg::ENC_RAW) begin
      end_phase = (hdr_need == 18'd0) ? PH_DONE : PH_RAW;
    end else if (hdr_enc == pprd_pkg::ENC_DELTA && (!ref_valid ||
                 18'(ref_bytes) != hdr_need || ref_pixels != hdr_cnt ||
                 ref_color != hdr_cs)) begin
      end_err = pprd_pkg::ST_KEYFRAME;
    end else begin
      end_phase = (hdr_cnt == 16'd0) ? PH_DONE : PH_COUNT;
    end
  end

  // A packet report carries its header fields only when the packet decoded cleanly.
  logic report_ok;
  assign report_ok = (header_pos == 5'(pprd_pkg::HDR_LEN)) &&
                     (error_code == pprd_pkg::ST_OK) && (phase == PH_DONE);

  always_comb begin
    rsp_next = '0;
    if (state == S_READ) begin
      rsp_next.result_kind = pprd_pkg::RES_READ;
      rsp_next.read_data   = mem_q;
    end else begin
      rsp_next.result_kind = pprd_pkg::RES_REPORT;
      if (header_pos < 5'(pprd_pkg::HDR_LEN)) begin
        rsp_next.status = pprd_pkg::ST_SHORT;
      end else if (error_code != pprd_pkg::ST_OK) begin
        rsp_next.status = error_code;
      end else if (phase != PH_DONE) begin
        rsp_next.status = pprd_pkg::ST_TRUNCATED;
      end else begin
        rsp_next.status   = pprd_pkg::ST_OK;
        rsp_next.seq      = header_latch[39:32];
        rsp_next.first_px = header_latch[31:16];
        rsp_next.px_count = h_count;
        rsp_next.encoding = h_enc;
        rsp_next.cspace   = h_cs;
        rsp_next.transfer = header_latch[47:40];
        rsp_next.body_len = need[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      buffer_bytes <= 13'd4096;
      ref_valid    <= 1'b0;
      ref_bytes    <= '0;
      ref_pixels   <= '0;
      ref_color    <= '0;
      header_latch <= '0;
      header_pos   <= '0;
      error_code   <= pprd_pkg::ST_OK;
      run_length   <= '0;
      pixel_hold   <= '0;
      pixels_done  <= '0;
      write_ptr    <= '0;
      byte_idx     <= '0;
      phase        <= PH_HEADER;
      run_left     <= '0;
      run_k        <= '0;
    end else begin
      if (cfg_we) begin
        buffer_bytes <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur   <= req.payload;
            state <= (req.payload.req_type == pprd_pkg::REQ_READ) ? S_READ : S_STEP;
          end
        end
        S_READ: begin
          out_reg <= rsp_next;
          state   <= S_OUT;
        end
        S_STEP: begin
          // One packet byte; runs hand off to the expansion loop, and the report
          // is formed after the run when the run ends the packet.
          if (header_pos < 5'(pprd_pkg::HDR_LEN)) begin
            header_latch <= hdr_hl;
            header_pos   <= header_pos + 5'd1;
            if (header_pos == 5'(pprd_pkg::HDR_LEN - 1)) begin
              error_code  <= end_err;
              phase       <= end_phase;
              write_ptr   <= '0;
              pixels_done <= '0;
              byte_idx    <= '0;
            end else begin
              error_code <= hdr_err;
            end
          end else begin
            priority case (phase)
              PH_RAW: begin
                write_ptr <= write_ptr + 18'd1;
                if (write_ptr + 18'd1 >= need) phase <= PH_DONE;
              end
              PH_COUNT: begin
                if (pixels_done + 17'(run_in) > {1'b0, h_count}) begin
                  phase <= PH_FAIL;
                  if (error_code == pprd_pkg::ST_OK) error_code <= pprd_pkg::ST_TRUNCATED;
                end else begin
                  run_length <= run_in;
                  pixel_hold <= '0;
                  byte_idx   <= '0;
                  phase      <= PH_PIXEL;
                end
              end
              PH_PIXEL: begin
                pixel_hold[8*byte_idx +: 8] <= cur.packet_byte;
                byte_idx <= byte_idx + 2'd1;
                if (run_start) begin
                  run_left <= run_length;
                  run_k    <= '0;
                end
              end
              default: ;
            endcase
          end
          if (run_start) begin
            state <= (h_enc == pprd_pkg::ENC_DELTA) ? S_RUNRD : S_RUNWR;
          end else if (cur.last_byte) begin
            state <= S_REPORT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUNRD: begin
          state <= S_RUNWR;
        end
        S_RUNWR: begin
          // Shared byte-write step; walks bytes of a pixel, then pixels of the run.
          if (run_k + 2'd1 >= bpp) begin
            run_k     <= '0;
            write_ptr <= write_ptr + 18'(bpp);
            run_left  <= run_left - 9'd1;
            if (run_left == 9'd1) begin
              pixels_done <= pixels_done + 17'(run_length);
              phase <= (pixels_done + 17'(run_length) >= {1'b0, h_count}) ? PH_DONE
                     : PH_COUNT;
              state <= cur.last_byte ? S_REPORT : S_IDLE;
            end else begin
              state <= (h_enc == pprd_pkg::ENC_DELTA) ? S_RUNRD : S_RUNWR;
            end
          end else begin
            run_k <= run_k + 2'd1;
            state <= (h_enc == pprd_pkg::ENC_DELTA) ? S_RUNRD : S_RUNWR;
          end
        end
        S_REPORT: begin
          // The report is captured from the finished packet, a clean packet becomes
          // the delta reference, and the packet state is cleared.
          out_reg <= rsp_next;
          if (report_ok) begin
            ref_valid  <= 1'b1;
            ref_bytes  <= need[12:0];
            ref_pixels <= h_count;
            ref_color  <= h_cs;
          end
          header_latch <= '0;
          header_pos   <= '0;
          error_code   <= pprd_pkg::ST_OK;
          run_length   <= '0;
          pixel_hold   <= '0;
          pixels_done  <= '0;
          write_ptr    <= '0;
          byte_idx     <= '0;
          phase        <= PH_HEADER;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUNWR) |-> (run_left != 9'd0)) else $error("empty run expanding");
  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_STEP || state == S_READ))
    else $error("accept not followed by work");
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
    else $error("result changed while waiting");

endmodule

>>> verif/pprd_scoreboard.sv
// Checker for the pixel packet decoder: predicts every result and compares it.
`timescale 1ns / 100ps

module pprd_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  pprd_req_if         req,
  pprd_rsp_if         rsp,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    DEC_HEADER, DEC_RAW, DEC_COUNT, DEC_PIXEL, DEC_DONE, DEC_FAIL
  } dec_phase_e;

  logic [7:0]  pixel_mem [0:pprd_pkg::FRAME_BYTES-1];
  logic [12:0] buf_size;
  bit          key_valid;
  int          key_bytes;
  logic [15:0] key_pixels;
  logic [1:0]  key_color;

  logic [1:0]  h_enc, h_cs;
  logic [7:0]  h_tf, h_seq;
  logic [15:0] h_start, h_count;
  int          hdr_pos, write_ptr, pixels_done, run_len, byte_idx;
  logic [3:0]  err_code;
  logic [23:0] pixel_hold;
  dec_phase_e  dphase;

  pprd_pkg::rsp_t status_q[$];
  int   errs;

  function automatic int px_size(logic [1:0] cs);
    return (cs == 2'd1 || cs == 2'd2) ? 2 : 3;
  endfunction

  function automatic int body_bytes();
    return int'(h_count) * px_size(h_cs);
  endfunction

  task automatic clear_packet();
    h_enc = '0; h_cs = '0; h_tf = '0; h_seq = '0; h_start = '0; h_count = '0;
    hdr_pos = 0; err_code = pprd_pkg::ST_OK; run_len = 0; pixel_hold = '0;
    pixels_done = 0; write_ptr = 0; byte_idx = 0; dphase = DEC_HEADER;
  endtask

  task automatic set_error(logic [3:0] code);
    if (err_code == pprd_pkg::ST_OK) err_code = code;
    dphase = DEC_FAIL;
  endtask

  task automatic finish_header();
    int limit;
    int need;
    limit = (buf_size < pprd_pkg::FRAME_BYTES) ? int'(buf_size) : pprd_pkg::FRAME_BYTES;
    need = body_bytes();
    if (err_code != pprd_pkg::ST_OK) begin
      dphase = DEC_FAIL;
    end else if (need > limit) begin
      set_error(pprd_pkg::ST_OVERFLOW);
    end else begin
      write_ptr = 0; pixels_done = 0; byte_idx = 0;
      if (h_enc == pprd_pkg::ENC_RAW) begin
        dphase = (need == 0) ? DEC_DONE : DEC_RAW;
      end else if (h_enc == pprd_pkg::ENC_DELTA && (!key_valid || key_bytes != need ||
                   key_pixels != h_count || key_color != h_cs)) begin
        set_error(pprd_pkg::ST_KEYFRAME);
      end else begin
        dphase = (h_count == 0) ? DEC_DONE : DEC_COUNT;
      end
    end
  endtask

  task automatic take_header(logic [7:0] b);
    case (hdr_pos)
      0: if (b != "D" && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_MAGIC;
      1: if (b != "M" && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_MAGIC;
      2: if (b != "X" && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_MAGIC;
      3: if (b != "2" && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_MAGIC;
      4: if (b != 8'd1 && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_VERSION;
      6: begin
        if (b > 8'd2 && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_ENCODING;
        h_enc = b[1:0];
      end
      7: begin
        if (b > 8'd3 && err_code == pprd_pkg::ST_OK) err_code = pprd_pkg::ST_COLOR;
        h_cs = b[1:0];
      end
      8: h_tf = b;
      9: h_seq = b;
      10: h_start[15:8] = b;
      11: h_start[7:0] = b;
      12: h_count[15:8] = b;
      13: h_count[7:0] = b;
      default: ;
    endcase
    hdr_pos++;
    if (hdr_pos == pprd_pkg::HDR_LEN) finish_header();
  endtask

  // Expands one completed run, XORing into the store for delta coding.
  task automatic expand_run();
    int bpp;
    int a;
    logic [7:0] v;
    bpp = px_size(h_cs);
    for (int r = 0; r < run_len; r++) begin
      for (int k = 0; k < bpp; k++) begin
        a = write_ptr + k;
        v = pixel_hold[8*k +: 8];
        if (a < pprd_pkg::FRAME_BYTES)
          pixel_mem[a] = (h_enc == pprd_pkg::ENC_DELTA) ? (pixel_mem[a] ^ v) : v;
      end
      write_ptr += bpp;
    end
    pixels_done += run_len;
    dphase = (pixels_done >= int'(h_count)) ? DEC_DONE : DEC_COUNT;
  endtask

  task automatic take_body(logic [7:0] b);
    int run;
    case (dphase)
      DEC_RAW: begin
        if (write_ptr < pprd_pkg::FRAME_BYTES) pixel_mem[write_ptr] = b;
        write_ptr++;
        if (write_ptr >= body_bytes()) dphase = DEC_DONE;
      end
      DEC_COUNT: begin
        run = (b == 8'd0) ? 256 : int'(b);
        if (pixels_done + run > int'(h_count)) begin
          set_error(pprd_pkg::ST_TRUNCATED);
        end else begin
          run_len = run; pixel_hold = '0; byte_idx = 0; dphase = DEC_PIXEL;
        end
      end
      DEC_PIXEL: begin
        pixel_hold[8*byte_idx +: 8] = b;
        byte_idx++;
        if (byte_idx >= px_size(h_cs)) expand_run();
      end
      default: ;
    endcase
  endtask

  task automatic decode_request(pprd_pkg::req_t r);
    pprd_pkg::rsp_t e;
    e = '0;
    if (r.req_type == pprd_pkg::REQ_READ) begin
      e.result_kind = pprd_pkg::RES_READ;
      e.read_data = pixel_mem[r.read_addr];
      status_q.push_back(e);
    end else begin
      if (hdr_pos < pprd_pkg::HDR_LEN) take_header(r.packet_byte);
      else take_body(r.packet_byte);
      if (r.last_byte) begin
        e.result_kind = pprd_pkg::RES_REPORT;
        if (hdr_pos < pprd_pkg::HDR_LEN) begin
          e.status = pprd_pkg::ST_SHORT;
        end else if (err_code != pprd_pkg::ST_OK) begin
          e.status = err_code;
        end else if (dphase != DEC_DONE) begin
          e.status = pprd_pkg::ST_TRUNCATED;
        end else begin
          key_valid = 1'b1;
          key_bytes = body_bytes();
          key_pixels = h_count;
          key_color = h_cs;
          e.status = pprd_pkg::ST_OK;
          e.seq = h_seq;
          e.first_px = h_start;
          e.px_count = h_count;
          e.encoding = h_enc;
          e.cspace = h_cs;
          e.transfer = h_tf;
          e.body_len = 13'(body_bytes());
        end
        status_q.push_back(e);
        clear_packet();
      end
    end
  endtask

  always @(posedge clk) begin
    pprd_pkg::rsp_t exp_r;
    if (rst) begin
      buf_size = 13'd4096;
      key_valid = 1'b0; key_bytes = 0; key_pixels = '0; key_color = '0;
      clear_packet();
      status_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) buf_size = cfg_wdata;
      if (req.valid && req.ready) decode_request(req.payload);
      if (rsp.valid && rsp.ready) begin
        if (status_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("Unexpected result %p", rsp.payload);
        end else begin
          exp_r = status_q.pop_front();
          if (rsp.payload !== exp_r) begin
            errs++;
            if (errs <= 10) $display("Mismatch: expected %p, got %p", exp_r, rsp.payload);
          end
        end
      end
    end
    pending <= status_q.size();
    fail_count <= errs;
  end

endmodule

>>> verif/tb_pixel_packet_rle_delta_decoder.sv
// Top of the decoder testbench: drives packets, reads and register writes.
`timescale 1ns / 100ps

module tb_pixel_packet_rle_delta_decoder;

  localparam int QUIET_LIMIT = 20000;
  localparam int ITEM_GOAL = 850;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  int          fail_count;
  int          pending;

  pprd_req_if req ();
  pprd_rsp_if rsp ();

  pixel_packet_rle_delta_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  pprd_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The clock runs at 125 MHz.
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Bytes of the packet being built, and what the testbench knows about
  // the delta reference that the last clean packet left behind.
  logic [7:0]  pkt[$];
  int          items;
  int          packets;
  int          reads;
  bit          quiet;
  int          cur_limit;
  bit          ref_known;
  logic [15:0] ref_count;
  logic [1:0]  ref_cs;

  // The receiver stalls in random bursts until the final stretch of the run.
  int stall_left;
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(1, 10);
    end else begin
      rsp.ready <= 1'b1;
      stall_left <= $urandom_range(1, 10);
    end
  end

  // The watchdog ends a run in which no request or result moves for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic int px_bytes(logic [1:0] cs);
    return (cs == 2'd1 || cs == 2'd2) ? 2 : 3;
  endfunction

  // Sends one request, sometimes after a random gap with valid low.
  task automatic send_req(logic t, logic [7:0] b, logic l, logic [11:0] a);
    pprd_pkg::req_t r;
    r.req_type = t;
    r.packet_byte = b;
    r.last_byte = l;
    r.read_addr = a;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk); while (!req.ready);
    items++;
  endtask

  task automatic read_byte(logic [11:0] a);
    send_req(pprd_pkg::REQ_READ, 8'($urandom), 1'($urandom), a);
    reads++;
  endtask

  // Sends the built packet; read requests are mixed in now and then, since
  // they must leave a packet in progress alone.
  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      if ($urandom_range(0, 15) == 0) read_byte(12'($urandom));
      send_req(pprd_pkg::REQ_PACKET, pkt[i], i == pkt.size() - 1, 12'($urandom));
    end
    packets++;
  endtask

  task automatic add_header(logic [7:0] enc_b, logic [7:0] cs_b, logic [15:0] start,
                            logic [15:0] count);
    pkt = {8'h44, 8'h4d, 8'h58, 8'h32, 8'd1, 8'($urandom), enc_b, cs_b,
           8'($urandom), 8'($urandom), start[15:8], start[7:0], count[15:8], count[7:0]};
  endtask

  // Appends (count, pixel) pairs that cover exactly count pixels.
  task automatic add_runs(int count, int bpp);
    int rem;
    int run;
    rem = count;
    while (rem > 0) begin
      if (rem >= 256 && $urandom_range(0, 3) == 0) run = 256;
      else run = $urandom_range(1, (rem < 255) ? rem : 255);
      pkt.push_back(8'(run));
      repeat (bpp) pkt.push_back(8'($urandom));
      rem -= run;
    end
  endtask

  // Builds a well-formed packet; delta packets follow the known reference.
  // Returns whether the packet should pass under the present size limit.
  task automatic build_good(output bit clean, output logic [15:0] cnt, output logic [1:0] cs);
    logic [1:0] enc;
    int need;
    if (ref_known && $urandom_range(0, 9) < 4) begin
      enc = pprd_pkg::ENC_DELTA;
      cnt = ref_count;
      cs = ref_cs;
    end else begin
      enc = ($urandom_range(0, 1) == 0) ? pprd_pkg::ENC_RAW : pprd_pkg::ENC_RLE;
      cs = 2'($urandom);
      if ($urandom_range(0, 19) == 0) cnt = 16'($urandom_range(200, 600));
      else if ($urandom_range(0, 15) == 0) cnt = 16'd0;
      else cnt = 16'($urandom_range(1, 24));
    end
    need = int'(cnt) * px_bytes(cs);
    add_header(8'(enc), 8'(cs), 16'($urandom), cnt);
    if (enc == pprd_pkg::ENC_RAW) repeat (need) pkt.push_back(8'($urandom));
    else add_runs(int'(cnt), px_bytes(cs));
    clean = (need <= cur_limit);
  endtask

  task automatic note_clean(bit clean, logic [15:0] cnt, logic [1:0] cs);
    if (clean) begin
      ref_known = 1'b1;
      ref_count = cnt;
      ref_cs = cs;
    end
  endtask

  // Waits for every expected result, lets the last run finish, then writes.
  task automatic write_limit(logic [12:0] v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = (v < pprd_pkg::FRAME_BYTES) ? int'(v) : pprd_pkg::FRAME_BYTES;
  endtask

  initial begin
    bit          clean;
    logic [15:0] cnt;
    logic [1:0]  cs;
    int          pick;
    int          phase_no;
    logic [12:0] limits[$];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.payload = '0;
    items = 0; packets = 0; reads = 0;
    quiet = 1'b0;
    cur_limit = pprd_pkg::FRAME_BYTES;
    ref_known = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The whole store is filled first, with eight runs of 256 two-byte
    // pixels, so that every later read finds written data.
    add_header(8'(pprd_pkg::ENC_RLE), 8'd1, 16'h0000, 16'd2048);
    repeat (8) begin
      pkt.push_back(8'd0);
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
    end
    send_packet();
    note_clean(1'b1, 16'd2048, 2'd1);
    read_byte(12'h000);
    read_byte(12'hfff);
    read_byte(12'haaa);
    read_byte(12'h555);

    // A packet shorter than the header reports short.
    pkt = {8'h44, 8'h4d, 8'h58};
    send_packet();
    // Bad magic, version, encoding and color; the earliest error wins.
    add_header(8'd0, 8'd0, 16'hffff, 16'd1);
    pkt[0] = 8'h00; pkt[4] = 8'hff;
    send_packet();
    add_header(8'd0, 8'd0, 16'h0000, 16'd1);
    pkt[4] = 8'hfe; pkt[6] = 8'hff;
    send_packet();
    add_header(8'hff, 8'hff, 16'h1234, 16'd1);
    send_packet();
    add_header(8'd0, 8'hff, 16'h1234, 16'd1);
    send_packet();
    // Pixel count beyond the store size overflows.
    add_header(8'(pprd_pkg::ENC_RAW), 8'd0, 16'h8000, 16'hffff);
    send_packet();
    // A delta whose size does not match the reference needs a keyframe.
    add_header(8'(pprd_pkg::ENC_DELTA), 8'd0, 16'h0001, 16'd5);
    add_runs(5, 3);
    send_packet();
    // A delta matching the fill packet is applied over the whole store.
    add_header(8'(pprd_pkg::ENC_DELTA), 8'd1, 16'h0000, 16'd2048);
    repeat (8) begin
      pkt.push_back(8'd0);
      pkt.push_back(8'hff);
      pkt.push_back(8'h81);
    end
    send_packet();
    read_byte(12'h7ff);
    read_byte(12'h800);
    // A run that passes the pixel count truncates and is not written.
    add_header(8'(pprd_pkg::ENC_RLE), 8'd3, 16'h0000, 16'd5);
    pkt.push_back(8'd6);
    pkt.push_back(8'h11); pkt.push_back(8'h22); pkt.push_back(8'h33);
    send_packet();
    read_byte(12'h000);
    // A raw packet that ends early is truncated, but its bytes stay written.
    add_header(8'(pprd_pkg::ENC_RAW), 8'd2, 16'h0000, 16'd4);
    pkt.push_back(8'hff); pkt.push_back(8'h00); pkt.push_back(8'h5a);
    send_packet();
    read_byte(12'h001);
    // Zero pixels is complete at the end of the header; trailing bytes are ignored.
    add_header(8'(pprd_pkg::ENC_RLE), 8'd0, 16'hffff, 16'd0);
    send_packet();
    note_clean(1'b1, 16'd0, 2'd0);
    add_header(8'(pprd_pkg::ENC_RAW), 8'd0, 16'h00ff, 16'd1);
    repeat (6) pkt.push_back(8'($urandom));
    send_packet();
    note_clean(1'b1, 16'd1, 2'd0);

    // Random part, split into phases with different store limits; each phase
    // change waits until every result has arrived.
    limits = {13'd0, 13'd60, 13'($urandom_range(1, 4095)), 13'd4096, 13'd4096};
    phase_no = 0;
    while (items < ITEM_GOAL) begin
      if (items > 200 + phase_no * 120 && phase_no < limits.size()) begin
        write_limit(limits[phase_no]);
        phase_no++;
      end
      if (items > ITEM_GOAL - 100) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        build_good(clean, cnt, cs);
        send_packet();
        note_clean(clean, cnt, cs);
      end else if (pick == 6) begin
        // A header byte that can never be right.
        build_good(clean, cnt, cs);
        pick = $urandom_range(0, 4);
        pkt[pick] = pkt[pick] ^ 8'($urandom_range(1, 255));
        send_packet();
      end else if (pick == 7) begin
        // The last bytes of a body are cut off.
        build_good(clean, cnt, cs);
        if (pkt.size() > pprd_pkg::HDR_LEN) begin
          repeat ($urandom_range(1, pkt.size() - pprd_pkg::HDR_LEN)) void'(pkt.pop_back());
        end
        send_packet();
        if (pkt.size() == pprd_pkg::HDR_LEN && cnt == 0) note_clean(clean, cnt, cs);
      end else if (pick == 8) begin
        // Noise.
        pkt.delete();
        repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
        send_packet();
      end else begin
        build_good(clean, cnt, cs);
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
          send_packet();
          note_clean(clean, cnt, cs);
        end else begin
          // Header with a run that overshoots the pixel count.
          add_header(8'(pprd_pkg::ENC_RLE), 8'(cs), 16'($urandom),
                     16'($urandom_range(1, 40)));
          pkt.push_back(8'(pkt[13] + 8'($urandom_range(1, 20))));
          repeat (3) pkt.push_back(8'($urandom));
          send_packet();
        end
      end
      repeat ($urandom_range(0, 2)) read_byte(12'($urandom));
    end
    if (cur_limit != pprd_pkg::FRAME_BYTES) write_limit(13'd4096);

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    $display("Sent %0d requests: %0d packets and %0d store reads.", items, packets, reads);
    $display("Store limits 0, 60, a random size and 4096 were used; %0d results left over.",
             pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
